// ----- hdl/erm_pkg.sv -----
// shared constants and types for the euler rotation matrix unit
// used by erm_sincos and euler_rotation_matrix_unit; no dependencies
package erm_pkg;

   // Q31 one and the degree-to-radian factor round(pi/180 * 2^40)
   localparam logic [31:0] Q_ONE = 32'h8000_0000;
   localparam logic [34:0] RAD_K = 35'd19190098069;
   localparam logic [17:0] RAD_K_LO = RAD_K[17:0];
   localparam logic [16:0] RAD_K_HI = RAD_K[34:18];

   // series divisors per step, a zero divisor marks a step with no work
   localparam int SERIES_STEPS = 6;
   localparam int unsigned COS_DIV [6] = '{132, 90, 56, 30, 12, 2};
   localparam int unsigned SIN_DIV [6] = '{0, 110, 72, 42, 20, 6};

   // pipeline depths: sine/cosine unit and matrix datapath
   localparam int SC_STAGES = 36;
   localparam int MX_STAGES = 7;

   // sine and cosine in sign-magnitude Q31
   typedef struct packed {
      logic [31:0] s_mag;
      logic        s_neg;
      logic [31:0] c_mag;
      logic        c_neg;
   } sincos_type;

endpackage

// ----- hdl/erm_sincos.sv -----
// pipelined sine and cosine of one angle in degrees, sign-magnitude Q31 out
// depends on erm_pkg
module erm_sincos #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic                   clock,
   input  logic signed [16:0]     angle,
   output erm_pkg::sincos_type    result
);

   localparam int FULL    = 360 << ANGLE_FRAC_BITS;
   localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
   localparam int HALF    = 45 << ANGLE_FRAC_BITS;
   localparam int OFFS    = ((65536 + FULL - 1) / FULL) * FULL;
   localparam int UW      = $clog2(OFFS + 65536);
   localparam int RQ      = $clog2(FULL);
   localparam int TW      = $clog2(HALF + 1);
   localparam int SW      = TW + 36;
   localparam int CH_COS  = 0;
   localparam int CH_SIN  = 1;
   localparam int NS      = erm_pkg::SERIES_STEPS;
   localparam int X2_LAST = 9 + 4 * (NS - 1);

   localparam logic [UW-1:0] FULL_U   = UW'(FULL);
   localparam logic [UW-1:0] OFFS_U   = UW'(OFFS);
   localparam logic [UW-1:0] MF       = UW'((64'd1 << UW) / FULL);
   localparam logic [RQ-1:0] Q1_R     = RQ'(QUARTER);
   localparam logic [RQ-1:0] Q2_R     = RQ'(2 * QUARTER);
   localparam logic [RQ-1:0] Q3_R     = RQ'(3 * QUARTER);
   localparam logic [RQ-1:0] HALF_R   = RQ'(HALF);

   logic signed [UW:0] ext;
   logic [UW:0]        u_sum;
   logic [UW-1:0]      u1_ff, u2_ff, u3_ff;
   logic [2*UW-1:0]    uq_ff;
   logic [UW-1:0]      qf_ff;
   logic [UW-1:0]      rr;
   logic [RQ-1:0]      r4_in, r4_ff;
   logic [RQ-1:0]      rem;
   logic [1:0]         quad;
   logic               swap;
   logic [TW-1:0]      t5_in, t5_ff;
   logic [TW+17:0]     pl_ff;
   logic [TW+16:0]     ph_ff;
   logic [SW-1:0]      xs;
   logic [30:0]        xd_ff [7:33];
   logic [61:0]        xx_ff;
   logic [30:0]        x2d_ff [9:X2_LAST];
   logic [2:0]         qsd_ff [5:35];
   logic [31:0]        t_at [2][NS+1];
   logic [62:0]        sp_ff;
   logic [31:0]        c34_ff;
   logic [31:0]        s35_ff, c35_ff;
   logic [31:0]        s_sw, c_sw;
   erm_pkg::sincos_type result_in, result_ff;

   // range reduction: bias to positive, reciprocal estimate, one correction
   always_comb begin
      ext   = (UW+1)'(angle);
      u_sum = ext + (UW+1)'(OFFS_U);
      rr    = u3_ff - qf_ff;
      r4_in = (rr >= FULL_U) ? RQ'(rr - FULL_U) : RQ'(rr);
   end

   // quadrant and fold to 0..45 degrees
   always_comb begin
      priority if (r4_ff >= Q3_R) begin
         quad = 2'd3;
         rem  = r4_ff - Q3_R;
      end else if (r4_ff >= Q2_R) begin
         quad = 2'd2;
         rem  = r4_ff - Q2_R;
      end else if (r4_ff >= Q1_R) begin
         quad = 2'd1;
         rem  = r4_ff - Q1_R;
      end else begin
         quad = 2'd0;
         rem  = r4_ff;
      end
      swap  = rem > HALF_R;
      t5_in = swap ? TW'(Q1_R - rem) : TW'(rem);
   end

   // radians: two partial products summed and rounded
   always_comb begin
      xs = (SW'(ph_ff) << 18) + SW'(pl_ff) + (SW'(1) << (ANGLE_FRAC_BITS + 8));
   end

   always_ff @(posedge clock) begin
      u1_ff    <= u_sum[UW-1:0];
      uq_ff    <= u1_ff * MF;
      u2_ff    <= u1_ff;
      qf_ff    <= UW'(uq_ff[2*UW-1:UW] * FULL_U);
      u3_ff    <= u2_ff;
      r4_ff    <= r4_in;
      t5_ff    <= t5_in;
      qsd_ff[5] <= {quad, swap};
      pl_ff    <= t5_ff * erm_pkg::RAD_K_LO;
      ph_ff    <= t5_ff * erm_pkg::RAD_K_HI;
      xd_ff[7] <= 31'(xs >> (ANGLE_FRAC_BITS + 9));
      xx_ff    <= xd_ff[7] * xd_ff[7];
      x2d_ff[9] <= 31'((63'(xx_ff) + (63'(1) << 30)) >> 31);
      for (int k = 8; k <= 33; k++) begin
         xd_ff[k] <= xd_ff[k-1];
      end
      for (int k = 10; k <= X2_LAST; k++) begin
         x2d_ff[k] <= x2d_ff[k-1];
      end
      for (int k = 6; k <= 35; k++) begin
         qsd_ff[k] <= qsd_ff[k-1];
      end
   end

   // horner steps: t = 1 - round(round(x2 * t) / d), four stages a step
   for (genvar ch = 0; ch < 2; ch++) begin : g_chain
      assign t_at[ch][0] = erm_pkg::Q_ONE;
      for (genvar it = 0; it < NS; it++) begin : g_step
         localparam int unsigned D =
            (ch == CH_COS) ? erm_pkg::COS_DIV[it] : erm_pkg::SIN_DIV[it];
         localparam int XS = 9 + 4 * it;
         if (D == 0) begin : g_skip
            assign t_at[ch][it+1] = t_at[ch][it];
         end else begin : g_series
            localparam logic [31:0] DV     = 32'(D);
            localparam logic [31:0] HALF_D = 32'(D / 2);
            localparam logic [31:0] RCP    = 32'((64'd1 << 32) / D);

            logic [62:0] pr_ff;
            logic [31:0] v, vp;
            logic [31:0] vp_ff, qe_ff, vp2_ff, qe2_ff, qd_ff;
            logic [31:0] rm;
            logic [31:0] t_in, t_ff;

            always_comb begin
               v    = 32'((63'(pr_ff) + (63'(1) << 30)) >> 31);
               vp   = v + HALF_D;
               rm   = vp2_ff - qd_ff;
               t_in = erm_pkg::Q_ONE - (qe2_ff + 32'(rm >= DV));
            end

            always_ff @(posedge clock) begin
               pr_ff  <= x2d_ff[XS] * t_at[ch][it];
               vp_ff  <= vp;
               qe_ff  <= 32'((64'(vp) * 64'(RCP)) >> 32);
               vp2_ff <= vp_ff;
               qe2_ff <= qe_ff;
               qd_ff  <= 32'(qe_ff * DV);
               t_ff   <= t_in;
            end

            assign t_at[ch][it+1] = t_ff;
         end
      end
   end

   // sine closes with one more product by x; quadrant signs last
   always_comb begin
      s_sw = qsd_ff[35][0] ? c35_ff : s35_ff;
      c_sw = qsd_ff[35][0] ? s35_ff : c35_ff;
      unique case (qsd_ff[35][2:1])
         2'd0: begin
            result_in = '{s_mag: s_sw, s_neg: 1'b0, c_mag: c_sw, c_neg: 1'b0};
         end
         2'd1: begin
            result_in = '{s_mag: c_sw, s_neg: 1'b0, c_mag: s_sw, c_neg: 1'b1};
         end
         2'd2: begin
            result_in = '{s_mag: s_sw, s_neg: 1'b1, c_mag: c_sw, c_neg: 1'b1};
         end
         2'd3: begin
            result_in = '{s_mag: c_sw, s_neg: 1'b1, c_mag: s_sw, c_neg: 1'b0};
         end
         default: begin
            result_in = '{s_mag: s_sw, s_neg: 1'b0, c_mag: c_sw, c_neg: 1'b0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sp_ff     <= xd_ff[33] * t_at[CH_SIN][NS];
      c34_ff    <= t_at[CH_COS][NS];
      s35_ff    <= 32'((64'(sp_ff) + (64'(1) << 30)) >> 31);
      c35_ff    <= c34_ff;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ----- hdl/euler_rotation_matrix_unit.sv -----
// top level: rotation matrix R = Rz * Ry * Rx from three angles, one row per result
// depends on erm_pkg and erm_sincos
//
// channel    ports                                   direction  handshake
// request    start, busy, req_angle_x/y/z            in         start high while busy low
// result     rsp_valid, rsp_row_index, rsp_col_*,    out        one-cycle strobe, no back-pressure
//            rsp_last_row
//
// a request is taken only while busy is low: busy stays high after each accepted request
// until its counter runs down, set by the four rows that share the one result port
// the datapath is a fixed 43-stage pipeline (36 in each sine/cosine unit, 7 in the
// matrix products and rounding); the first row is registered into the output registers
// from the last stage, and the other three follow in consecutive cycles
// reset clears the valid chain, the busy counter and the row sequencer; no storage to sweep
// the receiver never stalls; the busy spacing keeps rows of two requests apart
module euler_rotation_matrix_unit #(
   parameter int ENTRY_FRAC_BITS = 14,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [16:0] req_angle_x,
   input  logic signed [16:0] req_angle_y,
   input  logic signed [16:0] req_angle_z,
   output logic               rsp_valid,
   output logic [1:0]         rsp_row_index,
   output logic signed [15:0] rsp_col_zero,
   output logic signed [15:0] rsp_col_one,
   output logic signed [15:0] rsp_col_two,
   output logic signed [15:0] rsp_col_three,
   output logic               rsp_last_row
);

   localparam int LAT = erm_pkg::SC_STAGES + erm_pkg::MX_STAGES;
   localparam logic [33:0] ONE_E   = 34'(1) << ENTRY_FRAC_BITS;
   localparam logic [33:0] RND_E   = 34'(1) << (30 - ENTRY_FRAC_BITS);
   localparam logic [15:0] ONE_OUT = ONE_E[15:0];

   // level-one product slots
   localparam int P_SYSX = 0;
   localparam int P_SYCX = 1;
   localparam int P_CZCY = 2;
   localparam int P_SZCX = 3;
   localparam int P_SZSX = 4;
   localparam int P_SZCY = 5;
   localparam int P_CZCX = 6;
   localparam int P_CZSX = 7;
   localparam int P_CYSX = 8;
   localparam int P_CYCX = 9;

   // sign-magnitude to two's complement, wide enough for a sum of two terms
   function automatic logic signed [34:0] to_s(input logic [31:0] mag, input logic neg);
      logic signed [34:0] v;
      v = signed'({3'b000, mag});
      return neg ? -v : v;
   endfunction

   // request handshake: a counter loaded on accept holds busy high until it runs down
   logic       accept;
   logic [1:0] gap_ff, gap_in;

   assign busy   = (gap_ff != 2'd0);
   assign accept = start && !busy;

   always_comb begin
      priority if (accept) begin
         gap_in = 2'd3;
      end else if (gap_ff != 2'd0) begin
         gap_in = gap_ff - 2'd1;
      end else begin
         gap_in = gap_ff;
      end
   end

   // valid bit follows the request down the pipeline
   logic vld_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 2'd0;
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         gap_ff    <= gap_in;
         vld_ff[0] <= accept;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // one sine/cosine pipeline per axis
   erm_pkg::sincos_type scx, scy, scz;

   erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_x (
      .clock  (clock),
      .angle  (req_angle_x),
      .result (scx)
   );

   erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_y (
      .clock  (clock),
      .angle  (req_angle_y),
      .result (scy)
   );

   erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_z (
      .clock  (clock),
      .angle  (req_angle_z),
      .result (scz)
   );

   // level one: every product of two sines/cosines the matrix needs
   logic [31:0] l1a [10];
   logic [31:0] l1b [10];
   logic        l1an [10];
   logic        l1bn [10];

   always_comb begin
      l1a[P_SYSX] = scy.s_mag; l1an[P_SYSX] = scy.s_neg;
      l1b[P_SYSX] = scx.s_mag; l1bn[P_SYSX] = scx.s_neg;
      l1a[P_SYCX] = scy.s_mag; l1an[P_SYCX] = scy.s_neg;
      l1b[P_SYCX] = scx.c_mag; l1bn[P_SYCX] = scx.c_neg;
      l1a[P_CZCY] = scz.c_mag; l1an[P_CZCY] = scz.c_neg;
      l1b[P_CZCY] = scy.c_mag; l1bn[P_CZCY] = scy.c_neg;
      l1a[P_SZCX] = scz.s_mag; l1an[P_SZCX] = scz.s_neg;
      l1b[P_SZCX] = scx.c_mag; l1bn[P_SZCX] = scx.c_neg;
      l1a[P_SZSX] = scz.s_mag; l1an[P_SZSX] = scz.s_neg;
      l1b[P_SZSX] = scx.s_mag; l1bn[P_SZSX] = scx.s_neg;
      l1a[P_SZCY] = scz.s_mag; l1an[P_SZCY] = scz.s_neg;
      l1b[P_SZCY] = scy.c_mag; l1bn[P_SZCY] = scy.c_neg;
      l1a[P_CZCX] = scz.c_mag; l1an[P_CZCX] = scz.c_neg;
      l1b[P_CZCX] = scx.c_mag; l1bn[P_CZCX] = scx.c_neg;
      l1a[P_CZSX] = scz.c_mag; l1an[P_CZSX] = scz.c_neg;
      l1b[P_CZSX] = scx.s_mag; l1bn[P_CZSX] = scx.s_neg;
      l1a[P_CYSX] = scy.c_mag; l1an[P_CYSX] = scy.c_neg;
      l1b[P_CYSX] = scx.s_mag; l1bn[P_CYSX] = scx.s_neg;
      l1a[P_CYCX] = scy.c_mag; l1an[P_CYCX] = scy.c_neg;
      l1b[P_CYCX] = scx.c_mag; l1bn[P_CYCX] = scx.c_neg;
   end

   logic [63:0] p1_ff [10];
   logic        n1_ff [10];
   logic [31:0] m1_ff [10];
   logic        mn1_ff [10];
   logic [31:0] m1d3_ff [10];
   logic        mn1d3_ff [10];
   logic [31:0] m1d4_ff [10];
   logic        mn1d4_ff [10];
   erm_pkg::sincos_type z1_ff, z2_ff;
   logic [31:0] sym_ff [1:4];
   logic        syn_ff [1:4];

   // level two: cz and sz times the sy products
   logic [63:0] p2_ff [4];
   logic        n2_ff [4];
   logic [31:0] m2_ff [4];
   logic        mn2_ff [4];

   // entries: signed sum, magnitude, rounded and clamped 16-bit value
   logic signed [34:0] e_in [9];
   logic signed [34:0] e_ff [9];
   logic [33:0]        emag_ff [9];
   logic               eneg_ff [9];
   logic [33:0]        rr [9];
   logic [33:0]        rs [9];
   logic [15:0]        ent_ff [9];

   always_comb begin
      e_in[0] = to_s(m1d4_ff[P_CZCY], mn1d4_ff[P_CZCY]);
      e_in[1] = -to_s(m2_ff[0], mn2_ff[0]) - to_s(m1d4_ff[P_SZCX], mn1d4_ff[P_SZCX]);
      e_in[2] = -to_s(m2_ff[1], mn2_ff[1]) + to_s(m1d4_ff[P_SZSX], mn1d4_ff[P_SZSX]);
      e_in[3] = to_s(m1d4_ff[P_SZCY], mn1d4_ff[P_SZCY]);
      e_in[4] = -to_s(m2_ff[2], mn2_ff[2]) + to_s(m1d4_ff[P_CZCX], mn1d4_ff[P_CZCX]);
      e_in[5] = -to_s(m2_ff[3], mn2_ff[3]) - to_s(m1d4_ff[P_CZSX], mn1d4_ff[P_CZSX]);
      e_in[6] = to_s(sym_ff[4], syn_ff[4]);
      e_in[7] = to_s(m1d4_ff[P_CYSX], mn1d4_ff[P_CYSX]);
      e_in[8] = to_s(m1d4_ff[P_CYCX], mn1d4_ff[P_CYCX]);
      // round half away from zero, clamp to one
      for (int k = 0; k < 9; k++) begin
         rr[k] = (emag_ff[k] + RND_E) >> (31 - ENTRY_FRAC_BITS);
         if (rr[k] > ONE_E) begin
            rr[k] = ONE_E;
         end
         rs[k] = eneg_ff[k] ? (34'(0) - rr[k]) : rr[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 10; k++) begin
         p1_ff[k]    <= l1a[k] * l1b[k];
         n1_ff[k]    <= l1an[k] ^ l1bn[k];
         m1_ff[k]    <= 32'((p1_ff[k] + (64'(1) << 30)) >> 31);
         mn1_ff[k]   <= n1_ff[k];
         m1d3_ff[k]  <= m1_ff[k];
         mn1d3_ff[k] <= mn1_ff[k];
         m1d4_ff[k]  <= m1d3_ff[k];
         mn1d4_ff[k] <= mn1d3_ff[k];
      end
      z1_ff     <= scz;
      z2_ff     <= z1_ff;
      sym_ff[1] <= scy.s_mag;
      syn_ff[1] <= scy.s_neg;
      for (int k = 2; k <= 4; k++) begin
         sym_ff[k] <= sym_ff[k-1];
         syn_ff[k] <= syn_ff[k-1];
      end
      p2_ff[0] <= z2_ff.c_mag * m1_ff[P_SYSX];
      n2_ff[0] <= z2_ff.c_neg ^ mn1_ff[P_SYSX];
      p2_ff[1] <= z2_ff.c_mag * m1_ff[P_SYCX];
      n2_ff[1] <= z2_ff.c_neg ^ mn1_ff[P_SYCX];
      p2_ff[2] <= z2_ff.s_mag * m1_ff[P_SYSX];
      n2_ff[2] <= z2_ff.s_neg ^ mn1_ff[P_SYSX];
      p2_ff[3] <= z2_ff.s_mag * m1_ff[P_SYCX];
      n2_ff[3] <= z2_ff.s_neg ^ mn1_ff[P_SYCX];
      for (int k = 0; k < 4; k++) begin
         m2_ff[k]  <= 32'((p2_ff[k] + (64'(1) << 30)) >> 31);
         mn2_ff[k] <= n2_ff[k];
      end
      for (int k = 0; k < 9; k++) begin
         e_ff[k]    <= e_in[k];
         emag_ff[k] <= e_ff[k][34] ? 34'(-e_ff[k]) : 34'(e_ff[k]);
         eneg_ff[k] <= e_ff[k][34];
         ent_ff[k]  <= rs[k][15:0];
      end
   end

   // row sequencer: row 0 straight from the pipeline, rows 1 and 2 from holding
   // registers, row 3 is constant
   logic [1:0]  seq_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_row_index_ff;
   logic [15:0] rsp_col_zero_ff, rsp_col_one_ff, rsp_col_two_ff, rsp_col_three_ff;
   logic        rsp_last_row_ff;
   logic [15:0] hold1_ff [3];
   logic [15:0] hold2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (vld_ff[LAT-1]) begin
            seq_ff       <= 2'd1;
            rsp_valid_ff <= 1'b1;
         end else if (seq_ff != 2'd0) begin
            seq_ff       <= seq_ff + 2'd1;
            rsp_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (vld_ff[LAT-1]) begin
         rsp_row_index_ff <= 2'd0;
         rsp_col_zero_ff  <= ent_ff[0];
         rsp_col_one_ff   <= ent_ff[1];
         rsp_col_two_ff   <= ent_ff[2];
         rsp_col_three_ff <= 16'd0;
         rsp_last_row_ff  <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            hold1_ff[k] <= ent_ff[3 + k];
            hold2_ff[k] <= ent_ff[6 + k];
         end
      end else if (seq_ff == 2'd1) begin
         rsp_row_index_ff <= 2'd1;
         rsp_col_zero_ff  <= hold1_ff[0];
         rsp_col_one_ff   <= hold1_ff[1];
         rsp_col_two_ff   <= hold1_ff[2];
         rsp_col_three_ff <= 16'd0;
         rsp_last_row_ff  <= 1'b0;
      end else if (seq_ff == 2'd2) begin
         rsp_row_index_ff <= 2'd2;
         rsp_col_zero_ff  <= hold2_ff[0];
         rsp_col_one_ff   <= hold2_ff[1];
         rsp_col_two_ff   <= hold2_ff[2];
         rsp_col_three_ff <= 16'd0;
         rsp_last_row_ff  <= 1'b0;
      end else if (seq_ff == 2'd3) begin
         // homogeneous row
         rsp_row_index_ff <= 2'd3;
         rsp_col_zero_ff  <= 16'd0;
         rsp_col_one_ff   <= 16'd0;
         rsp_col_two_ff   <= 16'd0;
         rsp_col_three_ff <= ONE_OUT;
         rsp_last_row_ff  <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_col_zero  = rsp_col_zero_ff;
   assign rsp_col_one   = rsp_col_one_ff;
   assign rsp_col_two   = rsp_col_two_ff;
   assign rsp_col_three = rsp_col_three_ff;
   assign rsp_last_row  = rsp_last_row_ff;

endmodule

// ----- tb/euler_rotation_matrix_unit_checker.sv -----
// checker for the euler rotation matrix unit: watches request and result ports,
// predicts the four matrix rows per request and compares them; no package needed
`timescale 1ns / 1ps

module euler_rotation_matrix_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [16:0] req_angle_x,
   input  logic signed [16:0] req_angle_y,
   input  logic signed [16:0] req_angle_z,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_row_index,
   input  logic signed [15:0] rsp_col_zero,
   input  logic signed [15:0] rsp_col_one,
   input  logic signed [15:0] rsp_col_two,
   input  logic signed [15:0] rsp_col_three,
   input  logic               rsp_last_row,
   output int                 fail_count,
   output int                 rows_pending
);
   localparam int EFB = 14;
   localparam int AFB = 7;
   localparam logic [63:0] Q1 = 64'd1 << 31;
   localparam logic [63:0] QH = 64'd1 << 30;
   localparam logic [63:0] DEG2RAD = 64'd19190098069;

   typedef struct packed {
      logic [1:0]  row;
      logic [15:0] c0, c1, c2, c3;
      logic        last;
   } row_type;

   row_type row_queue[$];

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      return (a * b + QH) >> 31;
   endfunction

   function automatic logic [63:0] rdiv(logic [63:0] v, logic [63:0] d);
      return (v + d / 2) / d;
   endfunction

   function automatic logic [63:0] series_sin(logic [63:0] x);
      logic [63:0] x2, acc;
      int unsigned dv [5];
      dv = '{110, 72, 42, 20, 6};
      x2 = qmul(x, x);
      acc = Q1;
      for (int i = 0; i < 5; i++) acc = Q1 - rdiv(qmul(x2, acc), dv[i]);
      return qmul(x, acc);
   endfunction

   function automatic logic [63:0] series_cos(logic [63:0] x);
      logic [63:0] x2, acc;
      int unsigned dv [6];
      dv = '{132, 90, 56, 30, 12, 2};
      x2 = qmul(x, x);
      acc = Q1;
      for (int i = 0; i < 6; i++) acc = Q1 - rdiv(qmul(x2, acc), dv[i]);
      return acc;
   endfunction

   // fold angle to [0,45] degrees, then unfold by quadrant
   task automatic angle_sincos(input logic signed [16:0] ang,
                               output longint s, output longint c);
      longint full, quarter, r, rem, t, s0, c0;
      logic [63:0] x;
      int q;
      full = 360 << AFB;
      quarter = 90 << AFB;
      r = longint'(ang) % full;
      if (r < 0) r += full;
      q = int'(r / quarter);
      rem = r % quarter;
      t = (rem <= quarter / 2) ? rem : quarter - rem;
      x = (64'(t) * DEG2RAD + (64'd1 << (AFB + 8))) >> (AFB + 9);
      if (rem <= quarter / 2) begin
         s0 = longint'(series_sin(x));
         c0 = longint'(series_cos(x));
      end else begin
         s0 = longint'(series_cos(x));
         c0 = longint'(series_sin(x));
      end
      case (q & 3)
         0: begin s = s0; c = c0; end
         1: begin s = c0; c = -s0; end
         2: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0; end
      endcase
   endtask

   function automatic longint smul(longint a, longint b);
      logic [63:0] m;
      m = qmul(64'(a < 0 ? -a : a), 64'(b < 0 ? -b : b));
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   // round half away from zero, saturate to +-1.0
   function automatic logic [15:0] to_q14(longint v);
      logic [63:0] mag, r;
      mag = 64'(v < 0 ? -v : v);
      r = (mag + (64'd1 << (30 - EFB))) >> (31 - EFB);
      if (r > (64'd1 << EFB)) r = 64'd1 << EFB;
      if (v < 0) r = -r;
      return r[15:0];
   endfunction

   task automatic predict_rows(input logic signed [16:0] ax, ay, az);
      longint sx, cx, sy, cy, sz, cz, sysx, sycx;
      longint m [3][3];
      row_type r;
      angle_sincos(ax, sx, cx);
      angle_sincos(ay, sy, cy);
      angle_sincos(az, sz, cz);
      sysx = smul(sy, sx);
      sycx = smul(sy, cx);
      m[0][0] = smul(cz, cy);
      m[0][1] = -smul(cz, sysx) - smul(sz, cx);
      m[0][2] = -smul(cz, sycx) + smul(sz, sx);
      m[1][0] = smul(sz, cy);
      m[1][1] = -smul(sz, sysx) + smul(cz, cx);
      m[1][2] = -smul(sz, sycx) - smul(cz, sx);
      m[2][0] = sy;
      m[2][1] = smul(cy, sx);
      m[2][2] = smul(cy, cx);
      for (int i = 0; i < 3; i++) begin
         r = '{row: 2'(i), c0: to_q14(m[i][0]), c1: to_q14(m[i][1]),
               c2: to_q14(m[i][2]), c3: 16'd0, last: 1'b0};
         row_queue.push_back(r);
      end
      r = '{row: 2'd3, c0: 16'd0, c1: 16'd0, c2: 16'd0, c3: 16'd1 << EFB, last: 1'b1};
      row_queue.push_back(r);
   endtask

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      row_type w;
      if (!reset) begin
         if (rsp_valid) begin
            if (row_queue.size() == 0) begin
               report("row with nothing expected", 16'(rsp_row_index), 16'hxxxx);
            end else begin
               w = row_queue.pop_front();
               if (rsp_row_index !== w.row) report("row_index", 16'(rsp_row_index), 16'(w.row));
               if (rsp_col_zero !== w.c0) report("col_zero", rsp_col_zero, w.c0);
               if (rsp_col_one !== w.c1) report("col_one", rsp_col_one, w.c1);
               if (rsp_col_two !== w.c2) report("col_two", rsp_col_two, w.c2);
               if (rsp_col_three !== w.c3) report("col_three", rsp_col_three, w.c3);
               if (rsp_last_row !== w.last) report("last_row", 16'(rsp_last_row), 16'(w.last));
            end
         end
         if (start && !busy) predict_rows(req_angle_x, req_angle_y, req_angle_z);
      end
      rows_pending <= row_queue.size();
   end

endmodule

// ----- tb/euler_rotation_matrix_unit_tb.sv -----
// testbench top for euler_rotation_matrix_unit: drives angle requests and gives the verdict
// depends on euler_rotation_matrix_unit and euler_rotation_matrix_unit_checker
`timescale 1ns / 1ps

module euler_rotation_matrix_unit_tb;
   // no accepted request or row for this many cycles ends the run
   localparam int STALL_LIMIT = 2000;
   // pipeline latency of the block plus margin, used for the final drain
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_REQUESTS = 150;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [16:0] req_angle_x = '0;
   logic signed [16:0] req_angle_y = '0;
   logic signed [16:0] req_angle_z = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_row_index;
   logic signed [15:0] rsp_col_zero, rsp_col_one, rsp_col_two, rsp_col_three;
   logic               rsp_last_row;
   int                 fail_count, rows_pending;
   int                 idle_cycles;
   bit                 gaps_on = 1'b1;

   always #5 clock = ~clock;

   euler_rotation_matrix_unit DUT (.*);
   euler_rotation_matrix_unit_checker matrix_check (.*);

   // watchdog: counts cycles with no accepted request and no row
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("euler_rotation_matrix_unit_tb failed");
            $finish;
         end
      end
   end

   // present one request and hold it until accepted; random gaps before it
   task automatic send_angles(input logic signed [16:0] ax, ay, az);
      while (gaps_on && $urandom_range(99) < 32) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // any 17-bit pattern; mostly in the legal +-360 degree band, sometimes raw bits
   function automatic logic signed [16:0] pick_angle();
      case ($urandom_range(9))
         0: return 17'($urandom);
         1: return 17'(($urandom_range(7) * 45 - 180) * 128 + $urandom_range(2) - 1);
         default: return 17'(int'($urandom_range(92160)) - 46080);
      endcase
   endfunction

   initial begin
      logic signed [16:0] edges [10];
      edges = '{17'sd0, 17'sd46080, -17'sd46080, 17'sd11520, 17'sd5760,
                17'sd5761, 17'sd5759, -17'sd11520, 17'sd65535, -17'sd65536};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, full turns, quadrant and 45 degree fold points, raw extremes
      gaps_on = 1'b0;
      for (int i = 0; i < 10; i++) send_angles(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
      send_angles(17'sd65535, 17'sd65535, 17'sd65535);
      send_angles(-17'sd65536, -17'sd65536, -17'sd65536);
      send_angles(17'sd23040, -17'sd34560, 17'sd1);
      send_angles(-17'sd1, 17'sd11520, -17'sd23040);

      // random: long burst with no gaps, then the rest with gaps
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         gaps_on = (i >= 40);
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      start <= 1'b0;

      while (rows_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("euler_rotation_matrix_unit_tb passed");
      end else begin
         $display("euler_rotation_matrix_unit_tb failed");
      end
      $finish;
   end

endmodule
